FILE: rtl/ptw_pkg.sv
`default_nettype none

package ptw_pkg;

   localparam int DIR_ENTRIES_DEF      = 1024;
   localparam int NUM_TABLES_DEF       = 16;
   localparam int PAGE_OFFSET_BITS_DEF = 12;
   localparam int TABLE_INDEX_BITS     = 10;
   localparam int TABLE_SIZE           = 1024;
   localparam int DIR_INDEX_BITS       = 10;
   localparam int FRAME_BITS           = 20;
   localparam int CNT_W                = TABLE_INDEX_BITS + 1;
   localparam int OP_W                 = 2;
   localparam int STATUS_W             = 3;

   localparam logic [OP_W-1:0] OP_MAP       = 2'd0;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd1;
   localparam logic [OP_W-1:0] OP_UNMAP     = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DENIED      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_TABLE    = 3'd4;

   // second-level page entry, 24 bits
   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic                  accessed;
      logic                  user;
      logic                  write;
      logic                  present;
   } te_type;

   localparam int TE_W = $bits(te_type);

endpackage

`default_nettype wire

FILE: rtl/two_level_page_table_engine_core.sv
// Two-level page table engine, x86 32-bit layout (10/10/12 split).
// Request channel req_*: op (map, translate, unmap), virtual address,
// physical base, write and user flags. Response channel rsp_*: status and
// physical address, one response item per request item.
// The directory and all second-level tables sit in two synchronous RAMs;
// present counts and the free-slot map are flops.
// A walk passes through the directory read, the table read-modify-write
// and the result stage; it skips the table stage when the directory entry
// is absent on translate or unmap, or no table slot is free, and goes
// straight to the result stage for a misaligned request or the unused op.
// One item is in flight at a time: a new request is taken only once the
// last one has left the result stage.
// After reset a clearing pass writes every table entry and, in the same
// sweep, the directory; req_ready stays low meanwhile.
// A response waits in its output register while rsp_ready is low; the
// next item may already be accepted, and its result holds in the engine
// until the output register frees.
`default_nettype none

module two_level_page_table_engine_core
   import ptw_pkg::*;
#(
   parameter int DIR_ENTRIES      = DIR_ENTRIES_DEF,
   parameter int NUM_TABLES       = NUM_TABLES_DEF,
   parameter int PAGE_OFFSET_BITS = PAGE_OFFSET_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [31:0]         req_virtual_address,
   input  wire logic [31:0]         req_physical_base,
   input  wire logic                req_write_access,
   input  wire logic                req_user_mode,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [31:0]              rsp_physical_address
);

   localparam int SLOT_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int DIR_AW    = $clog2(DIR_ENTRIES);
   localparam int DE_W      = SLOT_W + 3;
   localparam int TAB_DEPTH = NUM_TABLES * TABLE_SIZE;
   localparam int TAB_AW    = SLOT_W + TABLE_INDEX_BITS;
   localparam int DIR_LSB   = PAGE_OFFSET_BITS + TABLE_INDEX_BITS;

   typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIR, S_TAB, S_FIN} state_type;

   state_type                state_ff, state_in;
   logic [TAB_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic [31:0]              va_ff, va_in;
   logic [31:0]              pb_ff, pb_in;
   logic                     wr_ff, wr_in;
   logic                     usr_ff, usr_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [31:0]              pa_ff, pa_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [31:0]              rsp_pa_ff, rsp_pa_in;
   logic [NUM_TABLES-1:0]    free_ff, free_in;
   logic [CNT_W-1:0]         cnt_ff [NUM_TABLES];
   logic [CNT_W-1:0]         cnt_in [NUM_TABLES];

   logic                     dir_we, dir_re;
   logic [DIR_AW-1:0]        dir_wa, dir_ra;
   logic [DE_W-1:0]          dir_wd, dir_q;
   logic                     tab_we, tab_re;
   logic [TAB_AW-1:0]        tab_wa, tab_ra;
   logic [TE_W-1:0]          tab_wd, tab_q;

   te_type                   te, te_new;
   logic                     accept;
   logic                     pick_found;
   logic [SLOT_W-1:0]        pick;
   logic [SLOT_W-1:0]        dslot;
   logic [CNT_W-1:0]         cnt_dec;

   ptw_ram #(.WIDTH(DE_W), .DEPTH(DIR_ENTRIES), .AW(DIR_AW)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wa),
      .wr_data (dir_wd),
      .rd_en   (dir_re),
      .rd_addr (dir_ra),
      .rd_data (dir_q)
   );

   ptw_ram #(.WIDTH(TE_W), .DEPTH(TAB_DEPTH), .AW(TAB_AW)) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wa),
      .wr_data (tab_wd),
      .rd_en   (tab_re),
      .rd_addr (tab_ra),
      .rd_data (tab_q)
   );

   assign req_ready            = (state_ff == S_IDLE);
   assign accept               = req_valid && req_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_physical_address = rsp_pa_ff;

   assign te    = te_type'(tab_q);
   assign dslot = dir_q[3 +: SLOT_W];

   // lowest free table slot
   always_comb begin
      pick_found = 1'b0;
      pick       = '0;
      for (int k = NUM_TABLES - 1; k >= 0; k--) begin
         if (free_ff[k]) begin
            pick_found = 1'b1;
            pick       = SLOT_W'(k);
         end
      end
   end

   assign cnt_dec = (cnt_ff[slot_ff] != '0) ? cnt_ff[slot_ff] - CNT_W'(1) : '0;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      va_in         = va_ff;
      pb_in         = pb_ff;
      wr_in         = wr_ff;
      usr_in        = usr_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      pa_in         = pa_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pa_in     = rsp_pa_ff;
      free_in       = free_ff;
      cnt_in        = cnt_ff;

      dir_we = 1'b0;
      dir_wa = va_ff[DIR_LSB +: DIR_AW];
      dir_wd = '0;
      dir_re = 1'b0;
      dir_ra = req_virtual_address[DIR_LSB +: DIR_AW];
      tab_we = 1'b0;
      tab_wa = {slot_ff, va_ff[PAGE_OFFSET_BITS +: TABLE_INDEX_BITS]};
      tab_wd = '0;
      tab_re = 1'b0;
      tab_ra = '0;
      te_new = te;

      case (state_ff)
         S_CLR: begin
            tab_we = 1'b1;
            tab_wa = clr_cnt_ff;
            if ((clr_cnt_ff >> DIR_AW) == '0) begin
               dir_we = 1'b1;
               dir_wa = clr_cnt_ff[DIR_AW-1:0];
            end
            clr_cnt_in = clr_cnt_ff + TAB_AW'(1);
            if (clr_cnt_ff == TAB_AW'(TAB_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               va_in     = req_virtual_address;
               pb_in     = req_physical_base;
               wr_in     = req_write_access;
               usr_in    = req_user_mode;
               status_in = ST_OK;
               pa_in     = '0;
               dir_re    = 1'b1;
               state_in  = S_DIR;
               if (req_op == OP_MAP &&
                   (req_virtual_address[PAGE_OFFSET_BITS-1:0] != '0 ||
                    req_physical_base[PAGE_OFFSET_BITS-1:0] != '0)) begin
                  status_in = ST_MISALIGNED;
                  state_in  = S_FIN;
               end else if (req_op == OP_UNMAP &&
                            req_virtual_address[PAGE_OFFSET_BITS-1:0] != '0) begin
                  status_in = ST_MISALIGNED;
                  state_in  = S_FIN;
               end else if (req_op != OP_MAP && req_op != OP_TRANSLATE &&
                            req_op != OP_UNMAP) begin
                  state_in = S_FIN;
               end
            end
         end
         S_DIR: begin
            state_in = S_TAB;
            slot_in  = dslot;
            if (!dir_q[0]) begin
               if (op_ff == OP_MAP) begin
                  if (!pick_found) begin
                     status_in = ST_NO_TABLE;
                     state_in  = S_FIN;
                  end else begin
                     slot_in       = pick;
                     free_in[pick] = 1'b0;
                     cnt_in[pick]  = '0;
                     dir_we        = 1'b1;
                     dir_wd        = {pick, usr_ff, wr_ff, 1'b1};
                  end
               end else begin
                  status_in = ST_NOT_PRESENT;
                  pa_in     = (op_ff == OP_TRANSLATE) ? '1 : '0;
                  state_in  = S_FIN;
               end
            end
            tab_re = 1'b1;
            tab_ra = {slot_in, va_ff[PAGE_OFFSET_BITS +: TABLE_INDEX_BITS]};
         end
         S_TAB: begin
            state_in = S_FIN;
            case (op_ff)
               OP_MAP: begin
                  if (!te.present) begin
                     cnt_in[slot_ff] = cnt_ff[slot_ff] + CNT_W'(1);
                  end
                  te_new.frame    = pb_ff[PAGE_OFFSET_BITS +: FRAME_BITS];
                  te_new.accessed = 1'b0;
                  te_new.user     = usr_ff;
                  te_new.write    = wr_ff;
                  te_new.present  = 1'b1;
                  tab_we          = 1'b1;
               end
               OP_TRANSLATE: begin
                  pa_in = '1;
                  if (!te.present) begin
                     status_in = ST_NOT_PRESENT;
                  end else if (wr_ff && usr_ff && !te.write) begin
                     status_in = ST_DENIED;
                  end else if (usr_ff && !te.user) begin
                     status_in = ST_DENIED;
                  end else begin
                     te_new.accessed = 1'b1;
                     tab_we          = 1'b1;
                     pa_in = {te.frame, va_ff[PAGE_OFFSET_BITS-1:0]};
                  end
               end
               default: begin
                  if (te.present) begin
                     te_new.present  = 1'b0;
                     tab_we          = 1'b1;
                     cnt_in[slot_ff] = cnt_dec;
                     if (cnt_dec == '0) begin
                        free_in[slot_ff] = 1'b1;
                        dir_we           = 1'b1;
                        dir_wd           = {dir_q[DE_W-1:1], 1'b0};
                     end
                  end
               end
            endcase
            tab_wd = te_new;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pa_in     = pa_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '1;
         for (int k = 0; k < NUM_TABLES; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         cnt_ff       <= cnt_in;
      end
      op_ff         <= op_in;
      va_ff         <= va_in;
      pb_ff         <= pb_in;
      wr_ff         <= wr_in;
      usr_ff        <= usr_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      pa_ff         <= pa_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pa_ff     <= rsp_pa_in;
   end

`ifndef SYNTH
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("response raised outside result stage");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == ST_OK || rsp_status_ff == ST_MISALIGNED ||
                        rsp_status_ff == ST_NOT_PRESENT || rsp_status_ff == ST_DENIED ||
                        rsp_status_ff == ST_NO_TABLE))
      else $error("illegal status code");
`endif

endmodule

`default_nettype wire

FILE: rtl/ptw_ram.sv
`default_nettype none

module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench
   import ptw_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_TABLES = NUM_TABLES_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [31:0]     va;
      logic [31:0]     pb;
      logic            wr;
      logic            usr;
   } page_req_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [31:0]         pa;
   } page_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = OP_MAP;
   logic [31:0] req_virtual_address = '0;
   logic [31:0] req_physical_base = '0;
   logic req_write_access = 1'b0;
   logic req_user_mode = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [31:0] rsp_physical_address;

   two_level_page_table_engine_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow page tables
   logic [6:0]  dir_tbl [DIR_ENTRIES_DEF];
   te_type      page_tbl [N_TABLES*TABLE_SIZE];
   int          live_cnt [N_TABLES];
   logic        slot_free [N_TABLES];

   page_req_t   pending_reqs [$];
   page_rsp_t   expected_rsps [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_rsp = 0;
   bit          failed = 1'b0;
   int          cycles = 0;
   bit          draining = 1'b0;

   function automatic int slot_of(logic [6:0] de);
      if (!de[0] || de[6:3] >= N_TABLES) return -1;
      return int'(de[6:3]);
   endfunction

   function automatic page_rsp_t walk_tables(page_req_t r);
      page_rsp_t o;
      int s, idx, k;
      te_type te;
      logic [9:0] di;
      di = r.va[31:22];
      o.status = ST_OK;
      o.pa = '0;
      case (r.op)
         OP_MAP: begin
            if (r.va[11:0] != 0 || r.pb[11:0] != 0) begin
               o.status = ST_MISALIGNED;
               return o;
            end
            s = slot_of(dir_tbl[di]);
            if (s < 0) begin
               for (k = 0; k < N_TABLES; k++)
                  if (slot_free[k]) begin
                     s = k;
                     break;
                  end
               if (s < 0) begin
                  o.status = ST_NO_TABLE;
                  return o;
               end
               slot_free[s] = 1'b0;
               live_cnt[s] = 0;
               dir_tbl[di] = {s[3:0], r.usr, r.wr, 1'b1};
            end
            idx = s*TABLE_SIZE + int'(r.va[21:12]);
            if (!page_tbl[idx].present) live_cnt[s]++;
            te.frame = r.pb[31:12];
            te.accessed = 1'b0;
            te.user = r.usr;
            te.write = r.wr;
            te.present = 1'b1;
            page_tbl[idx] = te;
         end
         OP_TRANSLATE: begin
            o.pa = '1;
            s = slot_of(dir_tbl[di]);
            if (s < 0) begin
               o.status = ST_NOT_PRESENT;
               return o;
            end
            idx = s*TABLE_SIZE + int'(r.va[21:12]);
            te = page_tbl[idx];
            if (!te.present) o.status = ST_NOT_PRESENT;
            else if (r.wr && r.usr && !te.write) o.status = ST_DENIED;
            else if (r.usr && !te.user) o.status = ST_DENIED;
            else begin
               page_tbl[idx].accessed = 1'b1;
               o.pa = {te.frame, r.va[11:0]};
            end
         end
         OP_UNMAP: begin
            if (r.va[11:0] != 0) begin
               o.status = ST_MISALIGNED;
               return o;
            end
            s = slot_of(dir_tbl[di]);
            if (s < 0) begin
               o.status = ST_NOT_PRESENT;
               return o;
            end
            idx = s*TABLE_SIZE + int'(r.va[21:12]);
            if (page_tbl[idx].present) begin
               page_tbl[idx].present = 1'b0;
               if (live_cnt[s] > 0) live_cnt[s]--;
               if (live_cnt[s] == 0) begin
                  slot_free[s] = 1'b1;
                  dir_tbl[di][0] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && !draining &&
                $urandom_range(99) >= send_idle_pct) begin
               page_req_t r;
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_op <= r.op;
               req_virtual_address <= r.va;
               req_physical_base <= r.pb;
               req_write_access <= r.wr;
               req_user_mode <= r.usr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // prediction at accept
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(walk_tables({req_op, req_virtual_address,
            req_physical_base, req_write_access, req_user_mode}));
   end

   // receiver readiness
   always @(posedge clock) begin
      if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      page_rsp_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected: status %0d pa %h",
               rsp_status, rsp_physical_address);
            failed = 1'b1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_physical_address !== e.pa) begin
               $error("physical_address: expected %h, got %h",
                  e.pa, rsp_physical_address);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[two_level_page_table_engine_core] ERROR");
         $finish;
      end
   end

   function automatic page_req_t mk(logic [1:0] op, logic [31:0] va, logic [31:0] pb,
                                    logic wr, logic usr);
      page_req_t r;
      r.op = op; r.va = va; r.pb = pb; r.wr = wr; r.usr = usr;
      return r;
   endfunction

   // page-aligned address from a small pool (directory only if dirs <= 20) so maps, translates and unmaps collide
   function automatic logic [31:0] pool_va(int dirs);
      logic [31:0] v;
      v = '0;
      v[31:22] = (dirs > 20) ? 10'($urandom) : 10'($urandom_range(dirs-1) * 37);
      v[21:12] = 10'($urandom_range(7));
      if ($urandom_range(9) == 0) v[21:12] = 10'($urandom);
      return v;
   endfunction

   task automatic wait_empty();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   task automatic add_random(int n, int dirs);
      int i, k;
      logic [31:0] va;
      page_req_t r;
      for (i = 0; i < n; i++) begin
         va = pool_va(dirs);
         k = $urandom_range(99);
         r = mk(OP_MAP, va, {20'($urandom), 12'h0}, 1'($urandom), 1'($urandom));
         if (k < 35) r.op = OP_MAP;
         else if (k < 70) begin
            r.op = OP_TRANSLATE;
            r.va[11:0] = 12'($urandom);
            r.pb = $urandom;
         end else if (k < 92) r.op = OP_UNMAP;
         else if (k < 96) r.op = OP_UNUSED;
         else begin
            r.va = $urandom;
            r.pb = $urandom;
            r.op = 2'($urandom_range(2));
         end
         if (r.op == OP_UNMAP || r.op == OP_UNUSED) r.pb = $urandom;
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      int i, ph;
      for (i = 0; i < DIR_ENTRIES_DEF; i++) dir_tbl[i] = '0;
      for (i = 0; i < N_TABLES*TABLE_SIZE; i++) page_tbl[i] = '0;
      for (i = 0; i < N_TABLES; i++) begin
         live_cnt[i] = 0;
         slot_free[i] = 1'b1;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'h0000_0abc, 32'h0, 1'b0, 1'b0));
      pending_reqs.push_back(mk(OP_UNMAP, 32'h0000_0000, 32'hffff_ffff, 1'b0, 1'b0));
      pending_reqs.push_back(mk(OP_MAP, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1));
      pending_reqs.push_back(mk(OP_MAP, 32'h0000_0000, 32'h0000_0800, 1'b1, 1'b1));
      pending_reqs.push_back(mk(OP_MAP, 32'h0000_0000, 32'hffff_f000, 1'b0, 1'b1));
      pending_reqs.push_back(mk(OP_MAP, 32'hffff_f000, 32'h0000_0000, 1'b1, 1'b0));
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'h0000_0fff, 32'h0, 1'b1, 1'b1));
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'h0000_0fff, 32'h0, 1'b0, 1'b1));
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'hffff_ffff, 32'h0, 1'b0, 1'b1));
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'hffff_ffff, 32'h0, 1'b1, 1'b0));
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'h0000_1000, 32'h0, 1'b0, 1'b0));
      // remap of a present page
      pending_reqs.push_back(mk(OP_MAP, 32'h0000_0000, 32'h1234_5000, 1'b1, 1'b1));
      pending_reqs.push_back(mk(OP_UNMAP, 32'h0000_0010, 32'h0, 1'b0, 1'b0));
      pending_reqs.push_back(mk(OP_UNMAP, 32'h0000_1000, 32'h0, 1'b0, 1'b0));
      pending_reqs.push_back(mk(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1));
      pending_reqs.push_back(mk(OP_UNMAP, 32'h0000_0000, 32'h0, 1'b0, 1'b0));
      pending_reqs.push_back(mk(OP_TRANSLATE, 32'h0000_0000, 32'h0, 1'b0, 1'b0));
      // exhaust the table slots, then one more directory
      for (i = 0; i < N_TABLES; i++)
         pending_reqs.push_back(mk(OP_MAP, {10'(i*3+1), 22'h0}, 32'h0000_1000, 1'b1, 1'b0));
      pending_reqs.push_back(mk(OP_MAP, 32'hff00_0000, 32'h0000_2000, 1'b0, 1'b0));
      wait_empty();
      for (i = 0; i < N_TABLES; i++)
         pending_reqs.push_back(mk(OP_UNMAP, {10'(i*3+1), 22'h0}, 32'h0, 1'b0, 1'b0));
      wait_empty();

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 55 : 0;
         recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 21 : 0;
         if (ph == 3) send_idle_pct = 21;
         if (ph == 0) begin
            hold_rsp = 300;
         end
         add_random(450, (ph == 2) ? 40 : 12);
         wait_empty();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (!failed)
         $display("[two_level_page_table_engine_core] OK");
      else
         $display("[two_level_page_table_engine_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
